/* rtl/tarp_pkg.sv */
// shared types and constants of the typed array record parser
package tarp_pkg;

  // result kinds, carried on tuser
  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_ELEMENT  = 2'd1,
    KIND_BAD_TYPE = 2'd2,
    KIND_BAD_LEN  = 2'd3
  } kind_t;

  // element type codes
  localparam logic [2:0] TYPE_INTE = 3'd0;
  localparam logic [2:0] TYPE_REAL = 3'd1;
  localparam logic [2:0] TYPE_DOUB = 3'd2;
  localparam logic [2:0] TYPE_LOGI = 3'd3;
  localparam logic [2:0] TYPE_CHAR = 3'd4;

  // four-character type tags as they arrive, first byte most significant
  localparam logic [31:0] TAG_INTE = 32'h494E_5445;
  localparam logic [31:0] TAG_REAL = 32'h5245_414C;
  localparam logic [31:0] TAG_DOUB = 32'h444F_5542;
  localparam logic [31:0] TAG_LOGI = 32'h4C4F_4749;
  localparam logic [31:0] TAG_CHAR = 32'h4348_4152;

  // fixed field sizes in bytes
  localparam logic [3:0] MARKER_BYTES = 4'd4;
  localparam logic [3:0] TYPE_BYTES   = 4'd4;

  // output word layout
  localparam int TDATA_W = 200;

  typedef struct packed {
    logic [33:0] element_index;
    logic [63:0] element_value;
    logic [30:0] element_count;
    logic [2:0]  type_code;
    logic [63:0] keyword;
  } result_t;

  // element size in bytes for a type code
  function automatic logic [3:0] elem_size(input logic [2:0] code);
    logic [3:0] sz;
    case (code)
      TYPE_DOUB: sz = 4'd8;
      TYPE_CHAR: sz = 4'd1;
      default:   sz = 4'd4;
    endcase
    return sz;
  endfunction

endpackage

/* rtl/typed_array_record_parser.sv */
// typed array record parser: splits a byte stream of length-marked records into results
//
// Takes one byte per accepted word on the slave side and parses big-endian,
// length-marked records: a header record (marker, keyword, element count, type
// code, marker) followed by data records (length, element bytes, trailer) until
// the array's element budget is used. One header result is given when the type
// code completes and one element result per assembled element, with tlast set
// on the element that uses up the budget. An unknown type or a bad record
// length gives an error result and the parser then ignores all bytes until
// reset. Each byte is handled in the cycle it is taken: the parser state and an
// output register update together, so one byte is accepted every clock while
// the master side keeps up; a held result stalls the input only while tready
// on the master side is low. The result appears in the cycle after its byte.
module typed_array_record_parser #(
  parameter int KEYWORD_BYTES = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // data_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // keyword[63:0], type_code[66:64], element_count[97:67],
  // element_value[161:98], element_index[195:162], zero pad
  output logic [tarp_pkg::TDATA_W-1:0] m_tdata,
  output logic [1:0]                  m_tuser,   // kind
  output logic                        m_tlast    // last_of_array
);
  import tarp_pkg::*;

  localparam int KW_W = 8 * KEYWORD_BYTES;

  // parse phases
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_KEY    = 3'd1;
  localparam logic [2:0] PH_COUNT  = 3'd2;
  localparam logic [2:0] PH_TYPE   = 3'd3;
  localparam logic [2:0] PH_TRAIL  = 3'd4;
  localparam logic [2:0] PH_RLEN   = 3'd5;
  localparam logic [2:0] PH_DATA   = 3'd6;
  localparam logic [2:0] PH_RTRAIL = 3'd7;

  logic [2:0]      phase, phase_next;
  logic [3:0]      fcount, fcount_next;
  logic [KW_W-1:0] keyword_reg, keyword_reg_next;
  logic [31:0]     count_reg, count_reg_next;
  logic [2:0]      elem_type, elem_type_next;
  logic [34:0]     remaining, remaining_next;
  logic [31:0]     rec_left, rec_left_next;
  logic [63:0]     assembly, assembly_next;
  logic [34:0]     position, position_next;
  logic            halted, halted_next;

  logic            accept;
  logic            res_valid;
  logic [1:0]      res_kind;
  logic            res_last;
  result_t         res;

  logic [3:0]      fcount_inc;
  logic [30:0]     declared;
  logic [3:0]      wsize;
  logic [31:0]     rec_shift;
  logic [31:0]     rec_dec;
  logic [31:0]     type_word;
  logic [63:0]     asm_shift;
  logic [34:0]     remaining_dec;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // shared helpers of the phase logic
  assign fcount_inc    = fcount + 4'd1;
  assign declared      = count_reg[31] ? 31'd0 : count_reg[30:0];
  assign wsize         = elem_size(elem_type);
  assign rec_shift     = {rec_left[23:0], s_tdata};
  assign rec_dec       = rec_left - 32'd1;
  assign type_word     = {assembly[23:0], s_tdata};
  assign asm_shift     = {assembly[55:0], s_tdata};
  assign remaining_dec = remaining - 35'd1;

  // phase logic for one byte
  always_comb begin
    phase_next       = phase;
    fcount_next      = fcount;
    keyword_reg_next = keyword_reg;
    count_reg_next   = count_reg;
    elem_type_next   = elem_type;
    remaining_next   = remaining;
    rec_left_next    = rec_left;
    assembly_next    = assembly;
    position_next    = position;
    halted_next      = halted;
    res_valid        = 1'b0;
    res_kind         = KIND_HEADER;
    res_last         = 1'b0;
    res.keyword       = 64'(keyword_reg);
    res.type_code     = elem_type;
    res.element_count = declared;
    res.element_value = 64'd0;
    res.element_index = 34'd0;
    if (!halted) begin
      case (phase)
        PH_LEAD: begin
          fcount_next = fcount_inc;
          if (fcount_inc >= MARKER_BYTES) begin
            keyword_reg_next = '0;
            phase_next       = PH_KEY;
            fcount_next      = 4'd0;
          end
        end
        PH_KEY: begin
          keyword_reg_next = (keyword_reg << 8) | KW_W'(s_tdata);
          fcount_next      = fcount_inc;
          if (fcount_inc >= 4'(KEYWORD_BYTES)) begin
            count_reg_next = 32'd0;
            phase_next     = PH_COUNT;
            fcount_next    = 4'd0;
          end
        end
        PH_COUNT: begin
          count_reg_next = {count_reg[23:0], s_tdata};
          fcount_next    = fcount_inc;
          if (fcount_inc >= MARKER_BYTES) begin
            assembly_next = 64'd0;
            phase_next    = PH_TYPE;
            fcount_next   = 4'd0;
          end
        end
        PH_TYPE: begin
          assembly_next = {32'd0, type_word};
          fcount_next   = fcount_inc;
          if (fcount_inc >= TYPE_BYTES) begin
            assembly_next = 64'd0;
            res_valid     = 1'b1;
            case (type_word)
              TAG_INTE: elem_type_next = TYPE_INTE;
              TAG_REAL: elem_type_next = TYPE_REAL;
              TAG_DOUB: elem_type_next = TYPE_DOUB;
              TAG_LOGI: elem_type_next = TYPE_LOGI;
              TAG_CHAR: elem_type_next = TYPE_CHAR;
              default:  elem_type_next = elem_type;
            endcase
            if (type_word != TAG_INTE && type_word != TAG_REAL &&
                type_word != TAG_DOUB && type_word != TAG_LOGI &&
                type_word != TAG_CHAR) begin
              halted_next   = 1'b1;
              res_kind      = KIND_BAD_TYPE;
              res.type_code = TYPE_INTE;
            end else begin
              res_kind       = KIND_HEADER;
              res.type_code  = elem_type_next;
              remaining_next = (elem_type_next == TYPE_CHAR) ? {1'b0, declared, 3'd0}
                                                             : {4'd0, declared};
              position_next  = 35'd0;
              phase_next     = PH_TRAIL;
              fcount_next    = 4'd0;
            end
          end
        end
        PH_TRAIL, PH_RTRAIL: begin
          fcount_next = fcount_inc;
          if (fcount_inc >= MARKER_BYTES) begin
            rec_left_next = 32'd0;
            phase_next    = (remaining != 35'd0) ? PH_RLEN : PH_LEAD;
            fcount_next   = 4'd0;
          end
        end
        PH_RLEN: begin
          rec_left_next = rec_shift;
          fcount_next   = fcount_inc;
          if (fcount_inc >= MARKER_BYTES) begin
            // sizes are powers of two, so the remainder is a mask
            if (rec_shift[31] || ((rec_shift[3:0] & (wsize - 4'd1)) != 4'd0)) begin
              halted_next = 1'b1;
              res_valid   = 1'b1;
              res_kind    = KIND_BAD_LEN;
            end else begin
              assembly_next = 64'd0;
              phase_next    = (rec_shift == 32'd0) ? PH_RTRAIL : PH_DATA;
              fcount_next   = 4'd0;
            end
          end
        end
        PH_DATA: begin
          assembly_next = asm_shift;
          fcount_next   = fcount_inc;
          rec_left_next = rec_dec;
          if (fcount_inc >= wsize) begin
            res_valid         = 1'b1;
            res_kind          = KIND_ELEMENT;
            res.element_value = (elem_type == TYPE_LOGI) ? {63'd0, |asm_shift} : asm_shift;
            res.element_index = position[33:0];
            if (remaining != 35'd0) begin
              remaining_next = remaining_dec;
              res_last       = (remaining_dec == 35'd0);
            end
            position_next = position + 35'd1;
            assembly_next = 64'd0;
            fcount_next   = 4'd0;
          end
          if (rec_dec == 32'd0) begin
            phase_next  = PH_RTRAIL;
            fcount_next = 4'd0;
          end
        end
        default: begin
          phase_next  = PH_LEAD;
          fcount_next = 4'd0;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      fcount      <= 4'd0;
      keyword_reg <= '0;
      count_reg   <= 32'd0;
      elem_type   <= TYPE_INTE;
      remaining   <= 35'd0;
      rec_left    <= 32'd0;
      assembly    <= 64'd0;
      position    <= 35'd0;
      halted      <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      fcount      <= fcount_next;
      keyword_reg <= keyword_reg_next;
      count_reg   <= count_reg_next;
      elem_type   <= elem_type_next;
      remaining   <= remaining_next;
      rec_left    <= rec_left_next;
      assembly    <= assembly_next;
      position    <= position_next;
      halted      <= halted_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      m_tdata <= TDATA_W'(res);
      m_tuser <= res_kind;
      m_tlast <= res_last;
    end
  end

endmodule

/* tb/testbench.sv */
// testbench for the typed array record parser: byte stream in, checked results out
`timescale 1ns / 100ps

module testbench;
  import tarp_pkg::*;

  localparam int KEY_BYTES    = 8;
  localparam int RANDOM_BYTES = 1030;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  // parser position within the record stream
  typedef enum logic [3:0] {
    P_LEAD, P_KEY, P_COUNT, P_TYPE, P_TRAIL, P_RLEN, P_DATA, P_RTRAIL
  } parse_step_t;

  // one result as the parser should give it
  typedef struct {
    kind_t       kind;
    logic [63:0] keyword;
    logic [2:0]  type_code;
    logic [30:0] count;
    logic [63:0] value;
    logic [33:0] index;
    logic        last;
  } parse_result_t;

  // one stream byte, with an optional hand-written result
  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    kind_t       kind;
    logic [63:0] value;
    logic        last;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'd0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;

  // parser model state
  parse_step_t parse_step   = P_LEAD;
  logic [3:0]  nbytes       = '0;
  logic [63:0] kw_reg       = '0;
  logic [31:0] cnt_reg      = '0;
  logic [2:0]  elem_code    = '0;
  logic [34:0] budget_left  = '0;
  logic [31:0] rec_left     = '0;
  logic [63:0] assembly     = '0;
  logic [34:0] position     = '0;
  bit          stopped      = 1'b0;

  parse_result_t pending_results[$];
  stim_row_t     stream_bytes[$];
  int            mismatches = 0;
  int            cycles = 0;
  bit            send_calm = 1'b0;
  bit            sink_calm = 1'b0;

  // empty CHAR array with a negative count: header only, count reads as zero
  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{8'h00, 1'b0, KIND_HEADER, 64'd0, 1'b0}, '{8'h00, 1'b0, KIND_HEADER, 64'd0, 1'b0},
    '{8'h00, 1'b0, KIND_HEADER, 64'd0, 1'b0}, '{8'h18, 1'b0, KIND_HEADER, 64'd0, 1'b0},
    '{8'hFF, 1'b0, KIND_HEADER, 64'd0, 1'b0}, '{8'hFF, 1'b0, KIND_HEADER, 64'd0, 1'b0},
    '{8'hFF, 1'b0, KIND_HEADER, 64'd0, 1'b0}, '{8'hFF, 1'b0, KIND_HEADER, 64'd0, 1'b0},
    '{8'hFF, 1'b0, KIND_HEADER, 64'd0, 1'b0}, '{8'hFF, 1'b0, KIND_HEADER, 64'd0, 1'b0},
    '{8'hFF, 1'b0, KIND_HEADER, 64'd0, 1'b0}, '{8'hFF, 1'b0, KIND_HEADER, 64'd0, 1'b0},
    '{8'hFF, 1'b0, KIND_HEADER, 64'd0, 1'b0}, '{8'hFF, 1'b0, KIND_HEADER, 64'd0, 1'b0},
    '{8'hFF, 1'b0, KIND_HEADER, 64'd0, 1'b0}, '{8'hFF, 1'b0, KIND_HEADER, 64'd0, 1'b0},
    '{8'h43, 1'b0, KIND_HEADER, 64'd0, 1'b0}, '{8'h48, 1'b0, KIND_HEADER, 64'd0, 1'b0},
    '{8'h41, 1'b0, KIND_HEADER, 64'd0, 1'b0}, '{8'h52, 1'b1, KIND_HEADER, 64'd0, 1'b0},
    '{8'h00, 1'b0, KIND_HEADER, 64'd0, 1'b0}, '{8'h00, 1'b0, KIND_HEADER, 64'd0, 1'b0},
    '{8'h00, 1'b0, KIND_HEADER, 64'd0, 1'b0}, '{8'h18, 1'b0, KIND_HEADER, 64'd0, 1'b0}
  };

  typed_array_record_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int size_of(input logic [2:0] code);
    case (code)
      TYPE_DOUB: return 8;
      TYPE_CHAR: return 1;
      default:   return 4;
    endcase
  endfunction

  function automatic logic [31:0] tag_of(input logic [2:0] code);
    case (code)
      TYPE_INTE: return TAG_INTE;
      TYPE_REAL: return TAG_REAL;
      TYPE_DOUB: return TAG_DOUB;
      TYPE_LOGI: return TAG_LOGI;
      default:   return TAG_CHAR;
    endcase
  endfunction

  // idle draw, with calm stretches of back-to-back words
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic parse_result_t shape_result(input kind_t k, input logic [2:0] code,
                                                 input logic [63:0] value,
                                                 input logic [34:0] index,
                                                 input logic last);
    parse_result_t r;
    r.kind      = k;
    r.keyword   = kw_reg;
    r.type_code = code;
    r.count     = cnt_reg[31] ? 31'd0 : cnt_reg[30:0];
    r.value     = value;
    r.index     = index[33:0];
    r.last      = last;
    return r;
  endfunction

  // advance the parser model by one byte
  task automatic predict_byte(input logic [7:0] b, output bit emitted,
                              output parse_result_t res);
    logic [31:0] tag;
    logic [63:0] value;
    logic        last;
    int          wsize;
    bit          known;
    emitted = 1'b0;
    res = shape_result(KIND_HEADER, 3'd0, 64'd0, 35'd0, 1'b0);
    if (stopped) return;
    case (parse_step)
      P_LEAD: begin
        nbytes++;
        if (nbytes >= 4) begin
          kw_reg = '0;
          parse_step = P_KEY;
          nbytes = '0;
        end
      end
      P_KEY: begin
        kw_reg = {kw_reg[55:0], b};
        nbytes++;
        if (nbytes >= KEY_BYTES) begin
          cnt_reg = '0;
          parse_step = P_COUNT;
          nbytes = '0;
        end
      end
      P_COUNT: begin
        cnt_reg = {cnt_reg[23:0], b};
        nbytes++;
        if (nbytes >= 4) begin
          assembly = '0;
          parse_step = P_TYPE;
          nbytes = '0;
        end
      end
      P_TYPE: begin
        assembly = {32'd0, assembly[23:0], b};
        nbytes++;
        if (nbytes >= 4) begin
          tag = assembly[31:0];
          assembly = '0;
          known = 1'b1;
          case (tag)
            TAG_INTE: elem_code = TYPE_INTE;
            TAG_REAL: elem_code = TYPE_REAL;
            TAG_DOUB: elem_code = TYPE_DOUB;
            TAG_LOGI: elem_code = TYPE_LOGI;
            TAG_CHAR: elem_code = TYPE_CHAR;
            default:  known = 1'b0;
          endcase
          emitted = 1'b1;
          if (!known) begin
            stopped = 1'b1;
            res = shape_result(KIND_BAD_TYPE, 3'd0, 64'd0, 35'd0, 1'b0);
          end else begin
            res = shape_result(KIND_HEADER, elem_code, 64'd0, 35'd0, 1'b0);
            // CHAR budget counts bytes, eight per declared element, once per array
            budget_left = {4'd0, res.count};
            if (elem_code == TYPE_CHAR) budget_left = budget_left << 3;
            position = '0;
            parse_step = P_TRAIL;
            nbytes = '0;
          end
        end
      end
      P_TRAIL, P_RTRAIL: begin
        nbytes++;
        if (nbytes >= 4) begin
          rec_left = '0;
          parse_step = (budget_left != 0) ? P_RLEN : P_LEAD;
          nbytes = '0;
        end
      end
      P_RLEN: begin
        rec_left = {rec_left[23:0], b};
        nbytes++;
        if (nbytes >= 4) begin
          wsize = size_of(elem_code);
          if (rec_left[31] || (rec_left % wsize) != 0) begin
            stopped = 1'b1;
            emitted = 1'b1;
            res = shape_result(KIND_BAD_LEN, elem_code, 64'd0, 35'd0, 1'b0);
          end else begin
            assembly = '0;
            parse_step = (rec_left == 0) ? P_RTRAIL : P_DATA;
            nbytes = '0;
          end
        end
      end
      P_DATA: begin
        wsize = size_of(elem_code);
        assembly = {assembly[55:0], b};
        nbytes++;
        rec_left--;
        if (nbytes >= wsize) begin
          value = assembly;
          if (elem_code == TYPE_LOGI) value = (value != 0) ? 64'd1 : 64'd0;
          last = 1'b0;
          // surplus elements past the budget keep last low
          if (budget_left != 0) begin
            budget_left--;
            last = (budget_left == 0);
          end
          emitted = 1'b1;
          res = shape_result(KIND_ELEMENT, elem_code, value, position, last);
          position++;
          assembly = '0;
          nbytes = '0;
          if (rec_left == 0) parse_step = P_RTRAIL;
        end else if (rec_left == 0) begin
          parse_step = P_RTRAIL;
          nbytes = '0;
        end
      end
      default: begin
        parse_step = P_LEAD;
        nbytes = '0;
      end
    endcase
  endtask

  // stream building
  task automatic push_byte(input logic [7:0] b);
    stim_row_t row;
    row = '{b: b, typed: 1'b0, kind: KIND_HEADER, value: 64'd0, last: 1'b0};
    stream_bytes = {stream_bytes, row};
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) push_byte(w[8*i +: 8]);
  endtask

  task automatic push_header(input logic [31:0] count, input logic [31:0] tag);
    push_word($urandom);
    repeat (KEY_BYTES) push_byte(8'($urandom_range(0, 255)));
    push_word(count);
    push_word(tag);
    push_word($urandom);
  endtask

  task automatic push_record(input int wsize, input int k);
    int pick;
    push_word(k * wsize);
    repeat (k) begin
      // all-zero and all-ones elements show up often, LOGI needs the zero case
      pick = $urandom_range(0, 5);
      repeat (wsize)
        push_byte(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
    end
    push_word($urandom);
  endtask

  // one well-formed array: header then data records until the budget runs out
  task automatic push_random_array();
    logic [2:0]  code;
    logic [31:0] count;
    int          budget;
    int          k;
    int          wsize;
    code = 3'($urandom_range(0, 4));
    case ($urandom_range(0, 9))
      0:       count = 32'd0;
      1:       count = 32'h8000_0000 | $urandom;
      default: count = $urandom_range(1, 6);
    endcase
    push_header(count, tag_of(code));
    budget = count[31] ? 0 : int'(count);
    if (code == TYPE_CHAR) budget = budget * 8;
    wsize = size_of(code);
    while (budget > 0) begin
      case ($urandom_range(0, 7))
        0:       k = 0;
        1:       k = budget + $urandom_range(1, 2);
        default: k = $urandom_range(1, budget);
      endcase
      push_record(wsize, k);
      budget -= (k < budget) ? k : budget;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    mismatches++;
    if (mismatches <= 100)
      $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, seen, wanted);
  endtask

  // result sink with random stalls
  initial begin : result_sink
    int stall;
    @(negedge rst);
    forever begin
      stall = draw_wait(sink_calm);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // result check against the oldest expectation
  result_t       seen_word;
  parse_result_t want;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_word = m_tdata[195:0];
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected", {62'd0, m_tuser}, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.kind)
          report_mismatch("kind", {62'd0, m_tuser}, {62'd0, want.kind});
        if (seen_word.keyword != want.keyword)
          report_mismatch("keyword", seen_word.keyword, want.keyword);
        if (seen_word.type_code != want.type_code)
          report_mismatch("type_code", {61'd0, seen_word.type_code}, {61'd0, want.type_code});
        if (seen_word.element_count != want.count)
          report_mismatch("element_count", {33'd0, seen_word.element_count}, {33'd0, want.count});
        if (seen_word.element_value != want.value)
          report_mismatch("element_value", seen_word.element_value, want.value);
        if (seen_word.element_index != want.index)
          report_mismatch("element_index", {30'd0, seen_word.element_index}, {30'd0, want.index});
        if (m_tlast != want.last)
          report_mismatch("last_of_array", {63'd0, m_tlast}, {63'd0, want.last});
      end
    end
  end

  // reset, stream build, byte driver and end of run
  initial begin : byte_source
    int            gap;
    int            wsize;
    int            k;
    bit            emitted;
    parse_result_t outcome;
    logic [2:0]    code;
    logic [31:0]   tag;
    logic [31:0]   bad_len;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) stream_bytes = {stream_bytes, DIRECTED_ROWS[i]};
    while (stream_bytes.size() < RANDOM_BYTES + 24) push_random_array();

    // the run ends on an error, after which the parser stays halted
    if ($urandom_range(0, 1) == 0) begin
      tag = $urandom;
      if ($urandom_range(0, 1) == 0)
        tag = tag_of(3'($urandom_range(0, 4))) ^ (32'd1 << $urandom_range(0, 31));
      while (tag == TAG_INTE || tag == TAG_REAL || tag == TAG_DOUB ||
             tag == TAG_LOGI || tag == TAG_CHAR)
        tag = $urandom;
      push_header($urandom_range(0, 6), tag);
    end else begin
      // largest count, one good record, then a negative length or one the type cannot divide
      code = 3'($urandom_range(0, 4));
      wsize = size_of(code);
      push_header(32'h7FFF_FFFF, tag_of(code));
      push_record(wsize, 2);
      k = $urandom_range(0, 3);
      if (code == TYPE_CHAR || $urandom_range(0, 2) == 0)
        bad_len = 32'h8000_0000 | $urandom;
      else
        bad_len = k * wsize + $urandom_range(1, wsize - 1);
      push_word(bad_len);
    end
    // ignored once halted
    repeat (8) push_byte(8'($urandom_range(0, 255)));

    foreach (stream_bytes[i]) begin
      gap = draw_wait(send_calm);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= stream_bytes[i].b;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      predict_byte(stream_bytes[i].b, emitted, outcome);
      if (stream_bytes[i].typed) begin
        emitted       = 1'b1;
        outcome.kind  = stream_bytes[i].kind;
        outcome.value = stream_bytes[i].value;
        outcome.last  = stream_bytes[i].last;
      end
      if (emitted) pending_results = {pending_results, outcome};
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
